### hw/rtl/cstl_pkg.sv
// Shared types, constants and the exp lookup table for the score-to-label block.
// Used by cstl_ctrl, cstl_dp and classifier_score_to_label_top.
package cstl_pkg;

  localparam int MaxClasses = 8;
  localparam int IdxW       = $clog2(MaxClasses);
  localparam int SeenW      = $clog2(MaxClasses + 1);
  localparam int ExpDepth   = 256;
  localparam int ExpAw      = $clog2(ExpDepth);

  localparam int ScoreW = 24;
  localparam int SumW   = 28;
  localparam int ExpSumW = 20;
  localparam int ConfW  = 17;
  localparam int LabelW = 4;
  localparam int DivW   = 33;
  localparam int DivCntW = 6;

  localparam logic [LabelW-1:0] LabelUnknown = 4'd8;
  localparam logic [SumW-1:0]   ProbSumLo    = 28'sd32768;
  localparam logic [SumW-1:0]   ProbSumHi    = 28'sd98304;
  localparam logic [ScoreW-1:0] OneQ16       = 24'd65536;

  // table step 16/depth in Q0.32
  localparam longint unsigned ExpStep = (64'd16 << 32) / ExpDepth;

  // configuration register indexes
  localparam logic [1:0] RegClassCount = 2'd0;
  localparam logic [1:0] RegUnkEnable  = 2'd1;
  localparam logic [1:0] RegUnkThresh  = 2'd2;

  typedef enum logic [2:0] {
    S_IN, S_CHECK, S_SUM, S_DRAIN, S_DINIT, S_DIV, S_OUT
  } state_e;

  typedef struct packed {
    logic            take;
    logic            exp_clear;
    logic            sum_step;
    logic [IdxW-1:0] sum_addr;
    logic            div_init;
    logic            div_step;
    logic            finish;
    logic            use_max;
  } cmd_t;

  typedef struct packed {
    logic             prob_row;
    logic [SeenW-1:0] seen;
  } sts_t;

  typedef logic [ConfW-1:0] exp_tab_t [ExpDepth];

  // truncating quotient of a 64-bit value by a small count, shift and subtract
  function automatic longint unsigned div_by_count(longint unsigned num,
                                                   longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16k/depth) in Q1.16, built as powers of a Taylor-series base
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t          tab;
    longint unsigned   x;
    longint unsigned   term;
    longint            acc;
    longint unsigned   base;
    longint unsigned   cur;
    longint unsigned   tmp;
    x    = ExpStep;
    term = 64'd1 << 32;
    acc  = longint'(term);
    for (int n = 1; n < 64; n++) begin
      if (term != 0) begin
        term = div_by_count((term * x) >> 32, 64'(n));
        if ((n & 1) == 1) acc = acc - longint'(term);
        else              acc = acc + longint'(term);
      end
    end
    base = longint'(acc);
    cur  = 64'd1 << 32;
    for (int k = 0; k < ExpDepth; k++) begin
      tmp    = (cur + 64'h8000) >> 16;
      tab[k] = tmp[ConfW-1:0];
      cur    = (cur * base + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

### hw/rtl/cstl_ctrl.sv
// Sequencer for the score-to-label block: row intake, exp sum, division, output.
// Depends on cstl_pkg.
module cstl_ctrl
  import cstl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.sum_addr = cnt_q[IdxW-1:0];
    case (state_q)
      S_IN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (last_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.prob_row) begin
          cmd_o.finish  = 1'b1;
          cmd_o.use_max = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.exp_clear = 1'b1;
          cnt_d           = '0;
          state_d         = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(sts_i.seen - 1'b1)) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_DINIT;
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        // DivW steps, then the result is latched on the following cycle
        if (cnt_q == DivCntW'(DivW)) begin
          cmd_o.finish = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IN;
      end
      default: state_d = S_IN;
    endcase
  end

endmodule

### hw/rtl/cstl_dp.sv
// Datapath: score store, running max, sums, exp lookup, serial divider, result regs.
// Depends on cstl_pkg.
module cstl_dp
  import cstl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [ConfW-1:0]   cfg_data_i,
  input  logic signed [ScoreW-1:0] score_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic [LabelW-1:0]  label_o,
  output logic [ConfW-1:0]   confidence_o,
  output logic [IdxW-1:0]    best_index_o
);

  logic [3:0]       class_count_q;
  logic             unk_en_q;
  logic [ConfW-1:0] unk_thr_q;

  logic signed [ScoreW-1:0] store_q [MaxClasses];
  logic signed [ScoreW-1:0] max_q;
  logic [IdxW-1:0]          pos_q;
  logic [SeenW-1:0]         seen_q;
  logic                     prob_q;
  logic signed [SumW-1:0]   sum_q;
  logic [ExpSumW-1:0]       esum_q;
  logic [ExpAw-1:0]         lk_idx_q;
  logic                     lk_vld_q, lk_hit_q;
  logic [ExpSumW:0]         rem_q;
  logic [DivW-1:0]          quo_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= 4'd8;
      unk_en_q      <= 1'b0;
      unk_thr_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegClassCount: class_count_q <= cfg_data_i[3:0];
        RegUnkEnable:  unk_en_q      <= cfg_data_i[0];
        RegUnkThresh:  unk_thr_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // row intake
  logic room;
  logic signed [ScoreW-1:0] score_ext;
  assign room      = seen_q < SeenW'(MaxClasses);
  assign score_ext = score_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && room) store_q[seen_q[IdxW-1:0]] <= score_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= '0;
      pos_q  <= '0;
      seen_q <= '0;
      prob_q <= 1'b1;
      sum_q  <= '0;
    end else if (cmd_i.finish) begin
      max_q  <= '0;
      pos_q  <= '0;
      seen_q <= '0;
      prob_q <= 1'b1;
      sum_q  <= '0;
    end else if (cmd_i.take && room) begin
      if (seen_q == '0 || score_ext > max_q) begin
        max_q <= score_ext;
        pos_q <= seen_q[IdxW-1:0];
      end
      if (score_ext < 0 || score_ext > $signed(OneQ16)) prob_q <= 1'b0;
      sum_q  <= sum_q + SumW'(score_ext);
      seen_q <= seen_q + 1'b1;
    end
  end

  assign sts_o.seen     = seen_q;
  assign sts_o.prob_row = prob_q && (sum_q > $signed(ProbSumLo)) && (sum_q < $signed(ProbSumHi));

  // exp lookup index: (max - score) * depth >> 20
  logic [ScoreW:0]      diff;
  logic [ScoreW+13:0]   prod;
  logic [ScoreW+13-20:0] idx_full;
  assign diff     = (ScoreW+1)'($signed({max_q[ScoreW-1], max_q})
                    - $signed({store_q[cmd_i.sum_addr][ScoreW-1], store_q[cmd_i.sum_addr]}));
  assign prod     = (ScoreW+14)'(diff) * (ScoreW+14)'(ExpDepth);
  assign idx_full = prod[ScoreW+13:20];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lk_vld_q <= 1'b0;
    else         lk_vld_q <= cmd_i.sum_step;
  end

  always_ff @(posedge clk_i) begin
    lk_idx_q <= idx_full[ExpAw-1:0];
    lk_hit_q <= idx_full < (ScoreW+14-20)'(ExpDepth);
  end

  // saturating exp sum
  logic [ConfW-1:0]   lk_val;
  logic [ExpSumW:0]   esum_add;
  assign lk_val   = lk_hit_q ? ExpTab[lk_idx_q] : '0;
  assign esum_add = {1'b0, esum_q} + (ExpSumW+1)'(lk_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) esum_q <= '0;
    else if (cmd_i.exp_clear) esum_q <= '0;
    else if (lk_vld_q) esum_q <= esum_add[ExpSumW] ? '1 : esum_add[ExpSumW-1:0];
  end

  // restoring divider, one quotient bit per cycle
  logic [ExpSumW:0] rem_sh;
  assign rem_sh = {rem_q[ExpSumW-1:0], quo_q[DivW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= {1'b1, 32'd0} + DivW'(esum_q >> 1);
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, esum_q}) begin
        rem_q <= rem_sh - {1'b0, esum_q};
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  // confidence and label
  logic [ConfW-1:0]  conf;
  logic [LabelW-1:0] lab;
  always_comb begin
    if (cmd_i.use_max)      conf = max_q[ConfW-1:0];
    else if (esum_q == '0)  conf = '0;
    else                    conf = quo_q[ConfW-1:0];
    if (unk_en_q && conf < unk_thr_q) lab = LabelUnknown;
    else if (class_count_q == 4'd8)   lab = LabelW'(pos_q);
    else if (class_count_q == 4'd7)   lab = LabelW'(pos_q) + 1'b1;
    else                              lab = LabelUnknown;
    if (lab > 4'd7) lab = LabelUnknown;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      label_o      <= lab;
      confidence_o <= conf;
      best_index_o <= pos_q;
    end
  end

endmodule

### hw/rtl/classifier_score_to_label_top.sv
// Top level of the classifier score-to-label block.
// Depends on cstl_pkg, cstl_ctrl and cstl_dp.
//
// Usage:
//   Scores of one pixel enter on the in channel, one item per cycle while
//   in_ready_o is high, the last marked by last_score_i. Up to 8 scores per
//   row are kept; extra ones are dropped. A row that ends gives one result
//   item (label, confidence, best_index) on the out channel.
//   A row whose scores look like probabilities (all in [0,1], sum strictly
//   between 0.5 and 1.5) skips the exp sum and division and gives its max
//   score as the confidence. Otherwise the exp sum runs over the stored
//   scores, then the serial divider forms the confidence (setup, 33 steps,
//   result latch).
//   The block holds one row at a time: in_ready_o is low from the last score
//   until the result is taken, so a new row cannot start before then.
//   A stalled receiver holds the result in the output registers.
//   Reset clears the row state and sets class_count 8, unknown check off,
//   threshold 0. The config port is always ready; write it while idle.
module classifier_score_to_label_top
  import cstl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [ConfW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [ScoreW-1:0] score_i,
  input  logic               last_score_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LabelW-1:0]  label_o,
  output logic [ConfW-1:0]   confidence_o,
  output logic [IdxW-1:0]    best_index_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  cstl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_score_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cstl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .score_i      (score_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .label_o      (label_o),
    .confidence_o (confidence_o),
    .best_index_o (best_index_o)
  );

endmodule

### tb/sv/classifier_score_to_label_top_test.sv
// Self-checking testbench for classifier_score_to_label_top.
// Depends on cstl_pkg and the block's RTL; predicts each row result in-line.
module classifier_score_to_label_top_test;
  import cstl_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [ConfW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [ScoreW-1:0] score_i;
  logic               last_score_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [LabelW-1:0]  label_o;
  logic [ConfW-1:0]   confidence_o;
  logic [IdxW-1:0]    best_index_o;

  classifier_score_to_label_top dut (.*);

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [ConfW-1:0]  conf;
    logic [IdxW-1:0]   idx;
  } label_res_t;

  // directed rows: one score per entry, expected result where obvious
  typedef struct {
    logic signed [ScoreW-1:0] score;
    logic                     last;
    logic                     has_exp;
    label_res_t               res;
  } stim_row_t;

  label_res_t  label_q[$];
  int          fail_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;
  bit          done;
  int          quiet_cycles;
  longint unsigned exp_lut[ExpDepth];

  // predictor state
  int signed   row_scores[MaxClasses];
  int signed   row_max;
  int          row_pos;
  int          row_seen;
  bit          row_prob;
  int signed   row_sum;
  int          cfg_classes;
  int          cfg_unk_en;
  int          cfg_thresh;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    fail_cnt++;
  endtask

  function automatic void build_lut();
    longint unsigned x, term, base, cur;
    longint acc;
    x = (64'd16 << 32) / ExpDepth;
    term = 64'd1 << 32;
    acc = longint'(term);
    for (int n = 1; n < 64; n++) begin
      if (term != 0) begin
        term = ((term * x) >> 32) / n;
        if (n % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
    end
    base = longint'(acc);
    cur = 64'd1 << 32;
    for (int k = 0; k < ExpDepth; k++) begin
      exp_lut[k] = (cur + 64'h8000) >> 16;
      cur = (cur * base + 64'h8000_0000) >> 32;
    end
  endfunction

  function automatic void clear_row();
    row_max = 0; row_pos = 0; row_seen = 0; row_prob = 1; row_sum = 0;
  endfunction

  // fold in one score; returns 1 with the label result at row end
  function automatic bit label_predict(input logic signed [ScoreW-1:0] s, input logic last,
                                       output label_res_t r);
    int signed v;
    longint unsigned esum, d, ix, conf, lab;
    v = s;
    if (row_seen < MaxClasses) begin
      row_scores[row_seen] = v;
      if (row_seen == 0 || v > row_max) begin
        row_max = v; row_pos = row_seen;
      end
      if (v < 0 || v > 65536) row_prob = 0;
      row_sum += v;
      row_seen++;
    end
    if (!last) return 0;
    if (row_prob && row_sum > 32768 && row_sum < 98304) begin
      conf = row_max;
    end else begin
      esum = 0;
      for (int i = 0; i < row_seen; i++) begin
        d = longint'(row_max - row_scores[i]) & 64'hFFFF_FFFF;
        ix = (d * ExpDepth) >> 20;
        if (ix < ExpDepth) esum += exp_lut[ix];
        if (esum > 64'hFFFFF) esum = 64'hFFFFF;
      end
      conf = (esum == 0) ? 0 : ((64'd1 << 32) + (esum >> 1)) / esum;
    end
    conf &= 64'h1FFFF;
    if (cfg_unk_en && conf < cfg_thresh) lab = LabelUnknown;
    else begin
      if (cfg_classes == 8) lab = row_pos;
      else if (cfg_classes == 7) lab = row_pos + 1;
      else lab = LabelUnknown;
      if (lab > 7) lab = LabelUnknown;
    end
    r.label = lab[LabelW-1:0];
    r.conf = conf[ConfW-1:0];
    r.idx = row_pos[IdxW-1:0];
    clear_row();
    return 1;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[ConfW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegClassCount: cfg_classes = value & 15;
      RegUnkEnable:  cfg_unk_en = value & 1;
      default:       cfg_thresh = value & 32'h1FFFF;
    endcase
    @(posedge clk_i);
  endtask

  // send one score; keeps valid high when the next item follows at once
  task automatic send_score(input logic signed [ScoreW-1:0] s, input logic last,
                            input bit has_exp, input label_res_t want);
    label_res_t r;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    score_i <= s;
    last_score_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (label_predict(s, last, r)) begin
      if (has_exp && r != want) report_mismatch("directed table", r, want);
      label_q.insert(label_q.size(), r);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (label_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [ScoreW-1:0] rand_score(input int mode);
    case (mode)
      0: return ScoreW'($urandom_range(65536, 0));
      1: return ScoreW'($urandom_range(20000, 0));
      2: return $signed(24'($urandom_range(600000, 0)) - 24'd300000);
      default: return ScoreW'($urandom());
    endcase
  endfunction

  // rows: mostly probability-like or spread scores of 7..8 entries
  task automatic random_rows(input int n_items);
    int cnt, len, mode;
    label_res_t none;
    none = '0;
    cnt = 0;
    while (cnt < n_items) begin
      len = ($urandom_range(9, 0) < 7) ? $urandom_range(8, 7) : $urandom_range(11, 1);
      mode = $urandom_range(3, 0);
      for (int i = 0; i < len; i++) begin
        if (mode == 0 && i == 0)
          send_score(ScoreW'($urandom_range(65536, 32768)), i == len - 1, 0, none);
        else send_score(rand_score(mode), i == len - 1, 0, none);
        cnt++;
      end
    end
  endtask

  // output checker and receiver idling
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (label_q.size() == 0) report_mismatch("unexpected result", label_o, -1);
      else begin
        label_res_t e;
        e = label_q.pop_front();
        if (label_o !== e.label) report_mismatch("label", label_o, e.label);
        if (confidence_o !== e.conf) report_mismatch("confidence", confidence_o, e.conf);
        if (best_index_o !== e.idx) report_mismatch("best_index", best_index_o, e.idx);
      end
    end
    out_ready_i <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni || done)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("classifier_score_to_label_top test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t tbl[$];
    label_res_t none;
    none = '0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 0; score_i = '0; last_score_i = 0; out_ready_i = 0;
    fail_cnt = 0; send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 0; done = 0;
    quiet_cycles = 0;
    cfg_classes = 8; cfg_unk_en = 0; cfg_thresh = 0;
    build_lut();
    clear_row();
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: probability row, extremes, long row, ties
    tbl.insert(tbl.size(), '{24'sd65536, 1, 1, '{4'd0, 17'd65536, 3'd0}});
    tbl.insert(tbl.size(), '{24'sd0, 0, 0, none});
    tbl.insert(tbl.size(), '{24'sd40000, 1, 1, '{4'd1, 17'd40000, 3'd1}});
    tbl.insert(tbl.size(), '{-24'sd8388608, 0, 0, none});
    tbl.insert(tbl.size(), '{24'sd8388607, 1, 0, none});
    tbl.insert(tbl.size(), '{24'sd5, 0, 0, none});
    tbl.insert(tbl.size(), '{24'sd5, 1, 1, '{4'd0, 17'd32768, 3'd0}});
    for (int i = 0; i < 10; i++)
      tbl.insert(tbl.size(), '{24'(i * 1000 - 3000), i == 9, 0, none});
    tbl.insert(tbl.size(), '{-24'sd1, 1, 1, '{4'd0, 17'd65536, 3'd0}});
    tbl.insert(tbl.size(), '{24'sd65537, 1, 1, '{4'd0, 17'd65536, 3'd0}});
    foreach (tbl[i]) send_score(tbl[i].score, tbl[i].last, tbl[i].has_exp, tbl[i].res);
    drain();

    // config sweeps with idling patterns
    write_reg(RegClassCount, 7);
    write_reg(RegUnkEnable, 1);
    write_reg(RegUnkThresh, 65536);
    send_idle_pct = 33; recv_idle_pct = 88;
    random_rows(120);
    drain();
    write_reg(RegClassCount, 8);
    write_reg(RegUnkThresh, $urandom_range(60000, 20000));
    send_idle_pct = 88; recv_idle_pct = 33;
    random_rows(120);
    drain();

    // long receiver hold while input keeps offering
    recv_hold = 1;
    fork
      begin repeat (300) @(posedge clk_i); recv_hold = 0; end
      random_rows(20);
    join
    drain();

    write_reg(RegClassCount, 5);
    write_reg(RegUnkEnable, 0);
    write_reg(RegUnkThresh, 0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_rows(30);
    drain();
    write_reg(RegClassCount, 8);
    write_reg(RegUnkEnable, 1);
    write_reg(RegUnkThresh, 1);
    random_rows(120);
    drain();

    done = 1;
    if (fail_cnt == 0) $display("classifier_score_to_label_top test passed");
    else $display("classifier_score_to_label_top test failed");
    $finish;
  end

endmodule
